>>> hdl/dhcprp_pkg.sv
// Shared types, constants and helper functions for the DHCP reply parser.
package dhcprp_pkg;

    localparam int DHCPRP_MAX_PAYLOAD = 2048;
    localparam int QUEUE_DEPTH        = 2;
    localparam int NUM_FIELDS         = 6;

    localparam logic [31:0] MAGIC_COOKIE = 32'h6382_5363;
    localparam logic [15:0] SERVER_PORT  = 16'd67;
    localparam logic [7:0]  OP_REPLY     = 8'd2;

    localparam logic [7:0] OPT_PAD    = 8'd0;
    localparam logic [7:0] OPT_MASK   = 8'd1;
    localparam logic [7:0] OPT_ROUTER = 8'd3;
    localparam logic [7:0] OPT_DNS    = 8'd6;
    localparam logic [7:0] OPT_LEASE  = 8'd51;
    localparam logic [7:0] OPT_TYPE   = 8'd53;
    localparam logic [7:0] OPT_SERVER = 8'd54;
    localparam logic [7:0] OPT_END    = 8'd255;

    localparam logic [7:0] TYPE_OFFER = 8'd2;
    localparam logic [7:0] TYPE_ACK   = 8'd5;
    localparam logic [7:0] TYPE_NAK   = 8'd6;

    // option walker phases
    localparam logic [1:0] PH_CODE = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_DATA = 2'd2;
    localparam logic [1:0] PH_DONE = 2'd3;

    // header faults
    localparam logic [1:0] FAULT_NONE   = 2'd0;
    localparam logic [1:0] FAULT_OP     = 2'd1;
    localparam logic [1:0] FAULT_COOKIE = 2'd2;

    // lease field slots
    localparam logic [2:0] F_YIADDR = 3'd0;
    localparam logic [2:0] F_MASK   = 3'd1;
    localparam logic [2:0] F_ROUTER = 3'd2;
    localparam logic [2:0] F_DNS    = 3'd3;
    localparam logic [2:0] F_SERVER = 3'd4;
    localparam logic [2:0] F_LEASE  = 3'd5;

    // result status codes
    localparam logic [3:0] ST_OFFER    = 4'd0;
    localparam logic [3:0] ST_ACK      = 4'd1;
    localparam logic [3:0] ST_NAK      = 4'd2;
    localparam logic [3:0] ST_OTHER    = 4'd3;
    localparam logic [3:0] ST_SHORT    = 4'd4;
    localparam logic [3:0] ST_PORT     = 4'd5;
    localparam logic [3:0] ST_NOTREPLY = 4'd6;
    localparam logic [3:0] ST_COOKIE   = 4'd7;
    localparam logic [3:0] ST_BADOPT   = 4'd8;
    localparam logic [3:0] ST_XID      = 4'd9;

    typedef logic [NUM_FIELDS-1:0][31:0] fields_t;

    // one finished packet, handed from the parser to the lease stage
    typedef struct packed {
        logic [3:0] status;
        fields_t    fields;
    } entry_t;

    typedef struct packed {
        logic       hit;
        logic [2:0] idx;
    } fsel_t;

    function automatic fsel_t field_of_option(input logic [7:0] code);
        fsel_t r;
        r = '{hit: 1'b1, idx: F_YIADDR};
        unique case (code)
            OPT_MASK:   r.idx = F_MASK;
            OPT_ROUTER: r.idx = F_ROUTER;
            OPT_DNS:    r.idx = F_DNS;
            OPT_SERVER: r.idx = F_SERVER;
            OPT_LEASE:  r.idx = F_LEASE;
            default:    r.hit = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] type_status(input logic [7:0] ptype);
        logic [3:0] s;
        unique case (ptype)
            TYPE_OFFER: s = ST_OFFER;
            TYPE_ACK:   s = ST_ACK;
            TYPE_NAK:   s = ST_NAK;
            default:    s = ST_OTHER;
        endcase
        return s;
    endfunction

endpackage

>>> hdl/dhcprp_front.sv
// Byte parser: header checks, option walk and packet classification.
module dhcprp_front
    import dhcprp_pkg::*;
#(
    parameter int MAX_PAYLOAD_BYTES = DHCPRP_MAX_PAYLOAD
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        in_accept,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic [15:0] udp_sport,
    output logic        push,
    output entry_t      push_entry
);

    localparam int POS_W = $clog2(MAX_PAYLOAD_BYTES + 1);
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_PAYLOAD_BYTES);
    localparam logic [POS_W-1:0] POS_OPTS  = POS_W'(240);

    logic [31:0]      xid_cfg_reg;
    logic [POS_W-1:0] pos_reg,    pos_next;
    logic [1:0]       phase_reg,  phase_next;
    logic [7:0]       code_reg,   code_next;
    logic [7:0]       remain_reg, remain_next;
    logic [7:0]       offset_reg, offset_next;
    logic [31:0]      shift_reg,  shift_next;
    logic [31:0]      xid_reg,    xid_next;
    logic [7:0]       type_reg,   type_next;
    fields_t          fields_reg, fields_next;
    logic [1:0]       fault_reg,  fault_next;
    fsel_t            fsel;
    logic [31:0]      shifted;

    assign fsel    = field_of_option(code_reg);
    assign shifted = {shift_reg[23:0], data_byte};

    always_comb begin
        pos_next    = pos_reg;
        phase_next  = phase_reg;
        code_next   = code_reg;
        remain_next = remain_reg;
        offset_next = offset_reg;
        shift_next  = shift_reg;
        xid_next    = xid_reg;
        type_next   = type_reg;
        fields_next = fields_reg;
        fault_next  = fault_reg;

        if (in_accept && (pos_reg < POS_LIMIT)) begin
            pos_next = pos_reg + POS_W'(1);
            if (pos_reg < POS_OPTS) begin
                shift_next = shifted;
                if (pos_reg == POS_W'(0) && data_byte != OP_REPLY && fault_reg == FAULT_NONE)
                    fault_next = FAULT_OP;
                if (pos_reg == POS_W'(7))
                    xid_next = shifted;
                if (pos_reg == POS_W'(19))
                    fields_next[F_YIADDR] = shifted;
                if (pos_reg == POS_W'(23) && shifted != 32'd0)
                    fields_next[F_SERVER] = shifted;
                if (pos_reg == POS_W'(239) && shifted != MAGIC_COOKIE
                    && fault_reg == FAULT_NONE)
                    fault_next = FAULT_COOKIE;
            end else begin
                unique case (phase_reg)
                    PH_CODE: begin
                        if (data_byte == OPT_END) begin
                            phase_next = PH_DONE;
                        end else if (data_byte != OPT_PAD) begin
                            code_next  = data_byte;
                            phase_next = PH_LEN;
                        end
                    end
                    PH_LEN: begin
                        remain_next = data_byte;
                        offset_next = 8'd0;
                        // message type with a wrong length is ignored
                        if (code_reg == OPT_TYPE && data_byte != 8'd1)
                            code_next = OPT_PAD;
                        phase_next = (data_byte == 8'd0) ? PH_CODE : PH_DATA;
                    end
                    PH_DATA: begin
                        shift_next = shifted;
                        if (code_reg == OPT_TYPE && offset_reg == 8'd0)
                            type_next = data_byte;
                        if (offset_reg == 8'd3 && fsel.hit)
                            fields_next[fsel.idx] = shifted;
                        if (offset_reg != 8'hFF)
                            offset_next = offset_reg + 8'd1;
                        remain_next = remain_reg - 8'd1;
                        if (remain_reg == 8'd1)
                            phase_next = PH_CODE;
                    end
                    default: begin
                        // after the end option: drop the rest
                    end
                endcase
            end
        end
    end

    // classify the packet as it stands after the last byte
    always_comb begin
        push              = in_accept && last_byte;
        push_entry.fields = fields_next;
        priority if (pos_next < POS_OPTS)
            push_entry.status = ST_SHORT;
        else if (udp_sport != SERVER_PORT)
            push_entry.status = ST_PORT;
        else if (fault_next == FAULT_OP)
            push_entry.status = ST_NOTREPLY;
        else if (fault_next == FAULT_COOKIE)
            push_entry.status = ST_COOKIE;
        else if (phase_next == PH_LEN || phase_next == PH_DATA)
            push_entry.status = ST_BADOPT;
        else if (xid_next != xid_cfg_reg)
            push_entry.status = ST_XID;
        else
            push_entry.status = type_status(type_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            xid_cfg_reg <= 32'd0;
        end else if (cfg_wr_en) begin
            xid_cfg_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || push) begin
            pos_reg    <= '0;
            phase_reg  <= PH_CODE;
            code_reg   <= 8'd0;
            remain_reg <= 8'd0;
            offset_reg <= 8'd0;
            shift_reg  <= 32'd0;
            xid_reg    <= 32'd0;
            type_reg   <= 8'd0;
            fields_reg <= '0;
            fault_reg  <= FAULT_NONE;
        end else begin
            pos_reg    <= pos_next;
            phase_reg  <= phase_next;
            code_reg   <= code_next;
            remain_reg <= remain_next;
            offset_reg <= offset_next;
            shift_reg  <= shift_next;
            xid_reg    <= xid_next;
            type_reg   <= type_next;
            fields_reg <= fields_next;
            fault_reg  <= fault_next;
        end
    end

endmodule

>>> hdl/dhcprp_fifo.sv
// Short queue of classified packets between the parser and the lease stage.
module dhcprp_fifo
    import dhcprp_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  entry_t push_data,
    output logic   full,
    input  logic   pop,
    output entry_t pop_data,
    output logic   empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    entry_t             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == CNT_W'(0));
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? PTR_W'(0) : p + PTR_W'(1);
    endfunction

    always_ff @(posedge aclk) begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (do_pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            count_reg <= count_next;
        end
    end

endmodule

>>> hdl/dhcprp_back.sv
// Lease stage: applies a classified packet to the stored lease and registers the result.
module dhcprp_back
    import dhcprp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic         q_empty,
    input  entry_t       q_data,
    output logic         q_pop,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [199:0] m_tdata
);

    fields_t      store_reg,  store_next, store_upd;
    logic [2:0]   flags_reg,  flags_next, flags_upd;  // {nak, ack, offer}
    logic         valid_reg;
    logic [199:0] data_reg;

    assign q_pop = !q_empty && (!valid_reg || m_tready);

    always_comb begin
        store_upd = store_reg;
        flags_upd = flags_reg;
        unique case (q_data.status)
            ST_OFFER: begin
                store_upd    = q_data.fields;
                flags_upd[0] = 1'b1;
            end
            ST_ACK: begin
                for (int i = 0; i < NUM_FIELDS; i++)
                    if (q_data.fields[i] != 32'd0)
                        store_upd[i] = q_data.fields[i];
                flags_upd[1] = 1'b1;
            end
            ST_NAK: flags_upd[2] = 1'b1;
            default: begin
                // hold the stored lease
            end
        endcase

        store_next = store_reg;
        flags_next = flags_reg;
        if (q_pop) begin
            store_next = store_upd;
            flags_next = flags_upd;
        end
        if (cfg_wr_en) begin
            store_next = '0;
            flags_next = 3'b000;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            store_reg <= '0;
            flags_reg <= 3'b000;
            valid_reg <= 1'b0;
        end else begin
            store_reg <= store_next;
            flags_reg <= flags_next;
            if (q_pop)
                valid_reg <= 1'b1;
            else if (m_tready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop)
            data_reg <= {1'b0, flags_upd, store_upd[F_LEASE], store_upd[F_SERVER],
                         store_upd[F_DNS], store_upd[F_ROUTER], store_upd[F_MASK],
                         store_upd[F_YIADDR], q_data.status};
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

>>> hdl/dhcp_reply_parser.sv
// Top level of the DHCPv4 reply parser.
//
// Usage:
//   The slave channel carries the UDP payload of one DHCP reply, one byte per
//   transaction; s_tlast marks the final byte, and the UDP source port rides in
//   s_tdata[23:8] and is sampled with it.
//   The master channel returns one status transaction per packet, on the final
//   byte only, holding the status code and the full stored lease and flags.
//   cfg_wr_en/cfg_wr_data load the expected transaction id and clear the
//   stored lease and flags; write it only while no packet is in flight.
// Throughput and result path:
//   One byte per cycle while s_tready is high. The accepted final byte puts
//   the packet into the queue; the lease stage registers the result at the
//   edge that pops it, which waits while a stalled result is still pending.
// Reset:
//   aresetn low clears the expected id, the stored lease, the flags, the parser
//   and the queue; no result is pending afterwards.
// Stall:
//   A stalled master side holds its result; the parser keeps taking bytes until
//   the two-entry packet queue fills, then drops s_tready.
module dhcp_reply_parser
    import dhcprp_pkg::*;
#(
    parameter int MAX_PAYLOAD_BYTES = DHCPRP_MAX_PAYLOAD
) (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration: expected transaction id
    input  logic         cfg_wr_en,
    input  logic [31:0]  cfg_wr_data,
    // payload bytes in
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [23:0]  s_tdata,   // [7:0] data_byte, [23:8] udp source port
    input  logic         s_tlast,   // last_byte
    // status out
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [199:0] m_tdata    // [3:0] status, [35:4] your_ip, [67:36] netmask,
                                    // [99:68] router_ip, [131:100] dns_ip,
                                    // [163:132] server_ip, [195:164] lease_seconds,
                                    // [196] offer flag, [197] ack flag,
                                    // [198] nak flag, [199] zero
);

    logic   q_full, q_empty, q_pop, push, in_accept;
    entry_t push_entry, pop_entry;

    // a byte is taken whenever the queue can absorb a finished packet
    assign s_tready  = !q_full;
    assign in_accept = s_tvalid && s_tready;

    dhcprp_front #(
        .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_accept   (in_accept),
        .data_byte   (s_tdata[7:0]),
        .last_byte   (s_tlast),
        .udp_sport   (s_tdata[23:8]),
        .push        (push),
        .push_entry  (push_entry)
    );

    dhcprp_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_entry),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_entry),
        .empty     (q_empty)
    );

    dhcprp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .q_empty   (q_empty),
        .q_data    (pop_entry),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

>>> hdl/dhcprp_checker.sv
// Port-level checks for the DHCP reply parser, bound to the top level.
module dhcprp_checker
    import dhcprp_pkg::*;
(
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [199:0] m_tdata
);

    // no result may survive a reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result pending after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[3:0] <= ST_XID))
        else $error("status code out of range");

    // an accepted offer or nak shows up in the flags of the same result
    a_offer_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3:0] == ST_OFFER |-> m_tdata[196])
        else $error("offer accepted without offer flag");

    a_nak_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3:0] == ST_NAK |-> m_tdata[198])
        else $error("nak received without nak flag");

endmodule

bind dhcp_reply_parser dhcprp_checker u_checker (.*);
